### sv/fxd_pkg.sv
package fxd_pkg;

   localparam int INT_DIGITS              = 5;
   localparam int MS_SHIFT                = 3;
   localparam int MAX_FRAC_DIGITS_DEFAULT = 6;
   localparam int QUEUE_DEPTH_DEFAULT     = 2;

   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_POINT = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // x / 10 equals (x * 0xcccd) >> 19 for every 16-bit x.
   localparam logic [15:0] DIV10_RECIP = 16'hcccd;
   localparam int          DIV10_SHIFT = 19;

   typedef logic [3:0] bcd_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_STEP,
      CONV_ROUND,
      CONV_PUSH
   } conv_state_type;

endpackage

### sv/fxd_channels.sv
interface fxd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        negative;
   logic [2:0]  digits;
   logic        millis;

   modport source (output valid, value, negative, digits, millis, input ready);
   modport sink (input valid, value, negative, digits, millis, output ready);
endinterface

interface fxd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, ch, last, input ready);
   modport sink (input valid, ch, last, output ready);
endinterface

### sv/fxd_conv.sv
module fxd_conv
   import fxd_pkg::*;
#(
   parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEFAULT,
   localparam int DIG_N = INT_DIGITS + MAX_FRAC_DIGITS,
   localparam int POS_W = $clog2(DIG_N + MS_SHIFT + 1),
   localparam int REC_W = 1 + 3 * POS_W + 4 * DIG_N
) (
   input  logic             clock,
   input  logic             reset,
   fxd_req_if.sink          req_chan,
   output logic             rec_valid,
   input  logic             rec_ready,
   output logic [REC_W-1:0] rec_data
);

   localparam int STEPS  = (MAX_FRAC_DIGITS > INT_DIGITS) ? MAX_FRAC_DIGITS : INT_DIGITS;
   localparam int STEP_W = $clog2(STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
   localparam logic [POS_W-1:0]  MAX_DEC   = POS_W'(MAX_FRAC_DIGITS);
   localparam logic [POS_W-1:0]  INT_POS   = POS_W'(INT_DIGITS);
   localparam logic [POS_W-1:0]  MS_POS    = POS_W'(INT_DIGITS + MS_SHIFT);
   localparam logic [POS_W-1:0]  SHIFT_POS = POS_W'(MS_SHIFT);

   conv_state_type state_ff, state_in;
   logic [15:0]        ip_ff, ip_in;
   logic [15:0]        frac_ff, frac_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [POS_W-1:0]   dec_ff, dec_in;
   logic [POS_W-1:0]   end_ff, end_in;
   logic [POS_W-1:0]   pt_ff, pt_in;
   logic [POS_W-1:0]   lim_ff, lim_in;
   logic               neg_ff, neg_in;
   logic               rnd_ff, rnd_in;
   bcd_type [INT_DIGITS-1:0]      int_dig_ff, int_dig_in;
   bcd_type [MAX_FRAC_DIGITS-1:0] frac_dig_ff, frac_dig_in;
   bcd_type [DIG_N-1:0]           dig_ff, dig_in;

   always_comb begin
      logic [31:0]                        q_prod;
      logic [15:0]                        q;
      logic [19:0]                        f10;
      bcd_type                            idig;
      logic [4*(MAX_FRAC_DIGITS+1)-1:0]   frac_cat;
      bcd_type [DIG_N-1:0]                all_d;
      logic                               run;
      logic [POS_W-1:0]                   dec_sum;
      logic [POS_W-1:0]                   dec_c;
      logic [POS_W-1:0]                   pt_c;
      logic [POS_W-1:0]                   end_c;
      logic [POS_W-1:0]                   start;

      state_in    = state_ff;
      ip_in       = ip_ff;
      frac_in     = frac_ff;
      step_in     = step_ff;
      dec_in      = dec_ff;
      end_in      = end_ff;
      pt_in       = pt_ff;
      lim_in      = lim_ff;
      neg_in      = neg_ff;
      rnd_in      = rnd_ff;
      int_dig_in  = int_dig_ff;
      frac_dig_in = frac_dig_ff;
      dig_in      = dig_ff;
      run         = 1'b0;

      req_chan.ready = (state_ff == CONV_IDLE);
      rec_valid      = (state_ff == CONV_PUSH);

      q_prod   = 32'(ip_ff) * 32'(DIV10_RECIP);
      q        = 16'(q_prod >> DIV10_SHIFT);
      idig     = bcd_type'(ip_ff - 16'(q * 16'd10));
      f10      = 20'(frac_ff) * 20'd10;
      frac_cat = {f10[19:16], frac_dig_ff};

      dec_sum = POS_W'(req_chan.digits) + (req_chan.millis ? SHIFT_POS : POS_W'(0));
      dec_c   = (dec_sum > MAX_DEC) ? MAX_DEC : dec_sum;
      pt_c    = req_chan.millis ? MS_POS : INT_POS;
      end_c   = INT_POS + dec_c;

      for (int i = 0; i < INT_DIGITS; i++) begin
         all_d[i] = int_dig_ff[i];
      end
      for (int j = 0; j < MAX_FRAC_DIGITS; j++) begin
         all_d[INT_DIGITS + j] = frac_dig_ff[j];
      end

      unique case (state_ff)
         CONV_IDLE: begin
            if (req_chan.valid) begin
               ip_in    = req_chan.value[31:16];
               frac_in  = req_chan.value[15:0];
               neg_in   = req_chan.negative;
               dec_in   = dec_c;
               pt_in    = pt_c;
               end_in   = end_c;
               lim_in   = ((pt_c < end_c) ? pt_c : end_c) - POS_W'(1);
               rnd_in   = req_chan.value[15];
               step_in  = '0;
               state_in = CONV_STEP;
            end
         end
         CONV_STEP: begin
            ip_in   = q;
            frac_in = f10[15:0];
            if (POS_W'(step_ff) < INT_POS) begin
               int_dig_in = {int_dig_ff[INT_DIGITS-2:0], idig};
            end
            if (POS_W'(step_ff) < MAX_DEC) begin
               frac_dig_in = frac_cat[4*(MAX_FRAC_DIGITS+1)-1:4];
            end
            // The round bit is the top of the residue after the last digit kept.
            if (POS_W'(step_ff) + POS_W'(1) == dec_ff) begin
               rnd_in = f10[15];
            end
            if (step_ff == STEP_LAST) begin
               state_in = CONV_ROUND;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         CONV_ROUND: begin
            run = rnd_ff;
            for (int i = DIG_N - 1; i >= 0; i--) begin
               dig_in[i] = all_d[i];
               if (POS_W'(i) < end_ff) begin
                  if (run) begin
                     dig_in[i] = (all_d[i] == bcd_type'(9) && i > 0) ?
                                 bcd_type'(0) : bcd_type'(all_d[i] + bcd_type'(1));
                  end
                  run = run && (all_d[i] == bcd_type'(9));
               end
            end
            state_in = CONV_PUSH;
         end
         CONV_PUSH: begin
            if (rec_ready) begin
               state_in = CONV_IDLE;
            end
         end
      endcase

      // Leading zeros are skipped, but never past the last integer digit shown.
      start = lim_ff;
      for (int i = DIG_N - 1; i >= 0; i--) begin
         if (POS_W'(i) < lim_ff && dig_ff[i] != bcd_type'(0)) begin
            start = POS_W'(i);
         end
      end

      rec_data = {neg_ff, start, end_ff, pt_ff, dig_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ip_ff       <= ip_in;
      frac_ff     <= frac_in;
      step_ff     <= step_in;
      dec_ff      <= dec_in;
      end_ff      <= end_in;
      pt_ff       <= pt_in;
      lim_ff      <= lim_in;
      neg_ff      <= neg_in;
      rnd_ff      <= rnd_in;
      int_dig_ff  <= int_dig_in;
      frac_dig_ff <= frac_dig_in;
      dig_ff      <= dig_in;
   end

endmodule

### sv/fxd_queue.sv
module fxd_queue
   import fxd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [WIDTH-1:0] slot_in [DEPTH];

   always_comb begin
      logic             push;
      logic             pop;
      logic [CNT_W-1:0] wr_idx;

      in_ready  = (count_ff < CNT_W'(DEPTH));
      out_valid = (count_ff != '0);
      out_data  = slot_ff[0];

      push   = in_valid && in_ready;
      pop    = out_valid && out_ready;
      wr_idx = count_ff - CNT_W'(pop);

      // The head always sits in the first slot; a pop moves the rest up one.
      for (int i = 0; i < DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
         if (pop && i < DEPTH - 1) begin
            slot_in[i] = slot_ff[(i + 1) % DEPTH];
         end
         if (push && wr_idx == CNT_W'(i)) begin
            slot_in[i] = in_data;
         end
      end

      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

### sv/fxd_emit.sv
module fxd_emit
   import fxd_pkg::*;
#(
   parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEFAULT,
   localparam int DIG_N = INT_DIGITS + MAX_FRAC_DIGITS,
   localparam int POS_W = $clog2(DIG_N + MS_SHIFT + 1),
   localparam int REC_W = 1 + 3 * POS_W + 4 * DIG_N
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rec_valid,
   output logic             rec_ready,
   input  logic [REC_W-1:0] rec_data,
   fxd_rsp_if.source        rsp_chan
);

   localparam int DIG_W = $clog2(DIG_N);

   logic                busy_ff, busy_in;
   logic                neg_ff, neg_in;
   logic                dot_ff, dot_in;
   logic [POS_W-1:0]    idx_ff, idx_in;
   logic [POS_W-1:0]    end_ff, end_in;
   logic [POS_W-1:0]    pt_ff, pt_in;
   bcd_type [DIG_N-1:0] dig_ff, dig_in;

   logic show_dot;
   logic is_last;
   logic take;

   always_comb begin
      logic                r_neg;
      logic [POS_W-1:0]    r_start;
      logic [POS_W-1:0]    r_end;
      logic [POS_W-1:0]    r_pt;
      bcd_type [DIG_N-1:0] r_dig;

      {r_neg, r_start, r_end, r_pt, r_dig} = rec_data;

      show_dot = (idx_ff == pt_ff) && !dot_ff;
      is_last  = !neg_ff && !show_dot && (idx_ff + POS_W'(1) == end_ff);

      priority if (neg_ff) begin
         rsp_chan.ch = CH_MINUS;
      end else if (show_dot) begin
         rsp_chan.ch = CH_POINT;
      end else begin
         rsp_chan.ch = CH_ZERO + 8'(dig_ff[idx_ff[DIG_W-1:0]]);
      end
      rsp_chan.valid = busy_ff;
      rsp_chan.last  = is_last;

      take      = busy_ff && rsp_chan.ready;
      rec_ready = !busy_ff || (take && is_last);

      busy_in = busy_ff;
      neg_in  = neg_ff;
      dot_in  = dot_ff;
      idx_in  = idx_ff;
      end_in  = end_ff;
      pt_in   = pt_ff;
      dig_in  = dig_ff;

      if (take) begin
         priority if (neg_ff) begin
            neg_in = 1'b0;
         end else if (show_dot) begin
            dot_in = 1'b1;
         end else if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + POS_W'(1);
         end
      end

      if (rec_valid && rec_ready) begin
         busy_in = 1'b1;
         neg_in  = r_neg;
         dot_in  = 1'b0;
         idx_in  = r_start;
         end_in  = r_end;
         pt_in   = r_pt;
         dig_in  = r_dig;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         neg_ff  <= 1'b0;
         dot_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         neg_ff  <= neg_in;
         dot_ff  <= dot_in;
      end
      idx_ff <= idx_in;
      end_ff <= end_in;
      pt_ff  <= pt_in;
      dig_ff <= dig_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff < end_ff)
      else $error("Character position has run past the end of the item.");

   a_drain_when_empty: assert property (@(posedge clock) disable iff (reset)
      (take && is_last && !rec_valid) |=> !busy_ff)
      else $error("Output stays valid after the final character with nothing queued.");

   a_hold_mid_item: assert property (@(posedge clock) disable iff (reset)
      (take && !is_last) |=> busy_ff)
      else $error("Output went idle before the final character of an item.");

endmodule

### sv/fixed16_16_to_decimal_text_top.sv
// After acceptance the converter makes one digit step per cycle, then a rounding step, and
// then hands the item to the queue; it takes a new item only once the last has gone there.
// The emitter sends one character per cycle while the receiver is ready, and each item is
// 1 to 7 + MAX_FRAC_DIGITS characters long.
// Reset is synchronous and active high; it empties the queue and idles both halves at once.
module fixed16_16_to_decimal_text_top
   import fxd_pkg::*;
#(
   parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEFAULT,
   parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   fxd_req_if.sink   req_chan,
   fxd_rsp_if.source rsp_chan
);

   localparam int DIG_N = INT_DIGITS + MAX_FRAC_DIGITS;
   localparam int POS_W = $clog2(DIG_N + MS_SHIFT + 1);
   localparam int REC_W = 1 + 3 * POS_W + 4 * DIG_N;

   logic             conv_valid;
   logic             conv_ready;
   logic [REC_W-1:0] conv_data;
   logic             emit_valid;
   logic             emit_ready;
   logic [REC_W-1:0] emit_data;

   fxd_conv #(
      .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rec_valid (conv_valid),
      .rec_ready (conv_ready),
      .rec_data  (conv_data)
   );

   fxd_queue #(
      .DEPTH(QUEUE_DEPTH),
      .WIDTH(REC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_valid),
      .in_ready  (conv_ready),
      .in_data   (conv_data),
      .out_valid (emit_valid),
      .out_ready (emit_ready),
      .out_data  (emit_data)
   );

   fxd_emit #(
      .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (emit_valid),
      .rec_ready (emit_ready),
      .rec_data  (emit_data),
      .rsp_chan  (rsp_chan)
   );

endmodule
